// ===== hw/rtl/dfft_pkg.sv =====
// Shared types and constants for the forward frame transmitter.
// No dependencies; imported by every module of the block.
`default_nettype none
package dfft_pkg;

  localparam int CMD_W      = 16;
  localparam int CMD_IDX_W  = $clog2(CMD_W);
  localparam int FRAME_BITS = 16;
  localparam int CNT_W      = 6;
  localparam int STOP_W     = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STOP_W-1:0] STOP_RESET      = STOP_W'(4);
  localparam logic [CNT_W:0]    START_HALF_BITS = (CNT_W+1)'(2);
  localparam logic [CNT_W:0]    DATA_HALF_BITS  = (CNT_W+1)'(2 * FRAME_BITS);

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_STOP  = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [CMD_W-1:0] command;
  } op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dali_forward_frame_transmitter.sv =====
// Top level of the forward frame Manchester transmitter.
// Instantiates dfft_front and dfft_back; depends on dfft_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): each word is either a half-bit tick
//   (in_req_type = 0) or a load (in_req_type = 1) carrying in_command.
//   A load starts a frame when idle; a load during a frame is refused and
//   reported with out_accepted = 0. Each tick drives one half-bit: start bit
//   one, FRAME_BITS data bits MSB first, then the configured number of low
//   stop half-bits. Bit 0 goes low then high, bit 1 high then low.
//   Result channel (out_valid/out_ready): exactly one result word per input
//   word, in order, with the line level, busy flag, accept flag and a
//   frame-end flag on the last stop half-bit.
//   Config channel (cfg_valid/cfg_ready): writes the stop length; always
//   ready; write only while the block is idle.
// Timing:
//   An accepted word passes through the two-entry front queue and then the
//   sequencer's output register before it appears on the result channel.
//   Throughput is one word per cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds, the queue fills,
//   and in_ready drops once both entries are taken.
// Reset:
//   Synchronous, active low: line low, idle, queue empty, stop length 4.
`default_nettype none
module dali_forward_frame_transmitter (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [dfft_pkg::STOP_W-1:0] cfg_stop_half_bits,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_req_type,
  input  wire  [dfft_pkg::CMD_W-1:0]  in_command,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_line_level,
  output logic                        out_busy_res,
  output logic                        out_accepted,
  output logic                        out_frame_end
);
  import dfft_pkg::*;

  // Queue between front and back.
  logic q_valid;
  logic q_ready;
  op_t  q_op;

  dfft_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_command  (in_command),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_op        (q_op)
  );

  dfft_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_stop_half_bits (cfg_stop_half_bits),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_op               (q_op),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_level     (out_line_level),
    .out_busy_res       (out_busy_res),
    .out_accepted       (out_accepted),
    .out_frame_end      (out_frame_end)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/dfft_front.sv =====
// Front end: accepts input words, classifies them into tick or load ops
// and holds them in a two-entry queue. Depends on dfft_pkg.
`default_nettype none
module dfft_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_req_type,
  input  wire  [dfft_pkg::CMD_W-1:0] in_command,
  output logic                       q_valid,
  input  wire                        q_ready,
  output dfft_pkg::op_t              q_op
);
  import dfft_pkg::*;

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  op_t               op_in;
  logic              push;
  logic              pop;

  // Classify: ticks carry no command.
  always_comb begin
    if (in_req_type == REQ_LOAD) begin
      op_in.kind    = OP_LOAD;
      op_in.command = in_command;
    end else begin
      op_in.kind    = OP_TICK;
      op_in.command = '0;
    end
  end

  assign in_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_op     = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

endmodule
`default_nettype wire

// ===== hw/rtl/dfft_back.sv =====
// Back end: frame sequencer that executes queued ops, holds the stop length
// register and the registered result word. Depends on dfft_pkg.
`default_nettype none
module dfft_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [dfft_pkg::STOP_W-1:0] cfg_stop_half_bits,
  input  wire                         q_valid,
  output logic                        q_ready,
  input  dfft_pkg::op_t               q_op,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_line_level,
  output logic                        out_busy_res,
  output logic                        out_accepted,
  output logic                        out_frame_end
);
  import dfft_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CMD_W-1:0]  frame_word_r, frame_word_nxt;
  logic              line_r, line_nxt;
  logic [STOP_W-1:0] stop_r;
  logic              out_valid_r;
  logic              out_line_r, out_busy_r, out_acc_r, out_fend_r;
  logic              acc_nxt, fend_nxt;
  logic              q_fire;
  logic              sub;
  logic [CNT_W:0]    cnt_inc;
  logic [CNT_W-1:0]  pos;
  logic              data_bit;

  assign cfg_ready = 1'b1;
  assign q_ready   = !out_valid_r || out_ready;
  assign q_fire    = q_valid && q_ready;

  assign sub     = count_r[0];
  assign cnt_inc = {1'b0, count_r} + (CNT_W+1)'(1);
  assign pos     = CNT_W'(FRAME_BITS - 1) - {1'b0, count_r[CNT_W-1:1]};
  assign data_bit = (pos < CNT_W'(CMD_W)) ? frame_word_r[pos[CMD_IDX_W-1:0]] : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      count_r      <= '0;
      frame_word_r <= '0;
      line_r       <= 1'b0;
      stop_r       <= STOP_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      count_r      <= count_nxt;
      frame_word_r <= frame_word_nxt;
      line_r       <= line_nxt;
      if (cfg_valid && cfg_ready) begin
        stop_r <= cfg_stop_half_bits;
      end
      if (q_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_fire) begin
      out_line_r <= line_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_acc_r  <= acc_nxt;
      out_fend_r <= fend_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    frame_word_nxt = frame_word_r;
    line_nxt       = line_r;
    acc_nxt        = 1'b0;
    fend_nxt       = 1'b0;
    if (q_fire) begin
      case (q_op.kind)
        OP_LOAD: begin
          // Refuse while a frame is on the line; the result reports out_accepted = 0.
          if (phase_r == PH_IDLE) begin
            frame_word_nxt = q_op.command;
            phase_nxt      = PH_START;
            count_nxt      = '0;
            acc_nxt        = 1'b1;
          end
        end
        default: begin
          case (phase_r)
            PH_IDLE: begin
              line_nxt = 1'b0;
            end
            PH_START: begin
              line_nxt  = ~sub;
              count_nxt = cnt_inc[CNT_W-1:0];
              if (cnt_inc >= START_HALF_BITS) begin
                phase_nxt = PH_DATA;
                count_nxt = '0;
              end
            end
            PH_DATA: begin
              line_nxt  = data_bit ^ sub;
              count_nxt = cnt_inc[CNT_W-1:0];
              if (cnt_inc >= DATA_HALF_BITS) begin
                phase_nxt = PH_STOP;
                count_nxt = '0;
              end
            end
            default: begin
              // Stop phase; a zero stop length ends after one half-bit.
              line_nxt  = 1'b0;
              count_nxt = cnt_inc[CNT_W-1:0];
              if (cnt_inc >= (CNT_W+1)'(stop_r)) begin
                phase_nxt = PH_IDLE;
                count_nxt = '0;
                fend_nxt  = 1'b1;
              end
            end
          endcase
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = out_line_r;
  assign out_busy_res   = out_busy_r;
  assign out_accepted   = out_acc_r;
  assign out_frame_end  = out_fend_r;

  a_fend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fend_r |-> !out_busy_r && !out_acc_r)
    else $error("frame end reported while still busy");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_acc_r |-> out_busy_r)
    else $error("accepted load without busy");

  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_busy_r |-> !out_line_r)
    else $error("line high while idle");

endmodule
`default_nettype wire
